### sv/blocking_message_mailbox_top_defines.svh
`ifndef BLOCKING_MESSAGE_MAILBOX_TOP_DEFINES_SVH
`define BLOCKING_MESSAGE_MAILBOX_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BMM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mailbox port check failed");

// next-cycle implication, disabled in reset
`define BMM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mailbox port check failed");

`endif

### sv/bmm_pkg.sv
`timescale 1ns / 1ps
package bmm_pkg;

  localparam int TASK_W = 4;
  localparam int CAP_W  = 8;
  localparam int CNT_W  = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

  localparam logic [1:0] REQ_SEND  = 2'd0;
  localparam logic [1:0] REQ_RECV  = 2'd1;
  localparam logic [1:0] REQ_CLOSE = 2'd2;
  localparam logic [1:0] REQ_OPEN  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BLOCKED  = 2'd1;
  localparam logic [1:0] ST_CLOSED   = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

endpackage

### sv/bmm_ram.sv
`timescale 1ns / 1ps
module bmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/blocking_message_mailbox_top.sv
`timescale 1ns / 1ps
// channel   handshake                 beat
// request   start & !busy             in_req_type, in_task_id, in_msg_data
// result    out_valid (one cycle)     out_status, out_rx_data, out_woken_valid,
//                                     out_woken_task, out_msg_count, out_last
// config    cfg_wr_en                 cfg_wr_data (capacity)
//
// Send, receive and open are accepted into registers, then handled by one memory
// read-modify-write step in S_EXEC; the result beat shows in the cycle after S_EXEC.
// Close with waiters releases one waiter per cycle from the waiter memories in
// S_EXEC, then S_DRAIN, results back to back; with no waiters it ends in S_EXEC.
// Reset is synchronous, active low, and needs no clearing pass.
// The receiver cannot stall; busy holds off requests while an item is in work.
module blocking_message_mailbox_top #(
  parameter int DEPTH     = 128,
  parameter int MSG_BITS  = 32,
  parameter int MAX_TASKS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_req_type,
  input  logic [bmm_pkg::TASK_W-1:0]  in_task_id,
  input  logic [MSG_BITS-1:0]         in_msg_data,
  input  logic                        cfg_wr_en,
  input  logic [bmm_pkg::CAP_W-1:0]   cfg_wr_data,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [MSG_BITS-1:0]         out_rx_data,
  output logic                        out_woken_valid,
  output logic [bmm_pkg::TASK_W-1:0]  out_woken_task,
  output logic [bmm_pkg::CNT_W-1:0]   out_msg_count,
  output logic                        out_last
);

  import bmm_pkg::*;

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CAPW = (CW > CAP_W) ? CW : CAP_W;
  localparam int QAW  = $clog2(MAX_TASKS);
  localparam int QCW  = $clog2(MAX_TASKS + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [CAP_W-1:0]     cap_r;
  logic [AW-1:0]        rptr_r, rptr_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 closed_r, closed_nxt;
  logic [QAW-1:0]       sh_r, sh_nxt, rh_r, rh_nxt;
  logic [QCW-1:0]       sc_r, sc_nxt, rc_r, rc_nxt;

  logic [1:0]           req_r, req_nxt;
  logic [TASK_W-1:0]    task_r, task_nxt;
  logic [MSG_BITS-1:0]  data_r, data_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [MSG_BITS-1:0]  out_rx_data_r, out_rx_data_nxt;
  logic                 out_woken_valid_r, out_woken_valid_nxt;
  logic [TASK_W-1:0]    out_woken_task_r, out_woken_task_nxt;
  logic [CNT_W-1:0]     out_msg_count_r, out_msg_count_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 msg_we;
  logic [AW-1:0]        msg_waddr;
  logic [MSG_BITS-1:0]  msg_rdata;
  logic                 sw_we, rw_we;
  logic [QAW-1:0]       sw_waddr, rw_waddr;
  logic [TASK_W-1:0]    sw_rdata, rw_rdata;

  logic [CAPW-1:0]      eff_cap;
  logic                 full;
  logic [AW:0]          msg_sum;
  logic [QAW:0]         sq_sum, rq_sum;
  logic [QCW:0]         wait_total;

  bmm_ram #(.WIDTH(MSG_BITS), .DEPTH(DEPTH)) u_msg_ram (
    .clk   (clk),
    .we    (msg_we),
    .waddr (msg_waddr),
    .wdata (data_r),
    .raddr (rptr_nxt),
    .rdata (msg_rdata)
  );

  bmm_ram #(.WIDTH(TASK_W), .DEPTH(MAX_TASKS)) u_send_wait_ram (
    .clk   (clk),
    .we    (sw_we),
    .waddr (sw_waddr),
    .wdata (task_r),
    .raddr (sh_nxt),
    .rdata (sw_rdata)
  );

  bmm_ram #(.WIDTH(TASK_W), .DEPTH(MAX_TASKS)) u_recv_wait_ram (
    .clk   (clk),
    .we    (rw_we),
    .waddr (rw_waddr),
    .wdata (task_r),
    .raddr (rh_nxt),
    .rdata (rw_rdata)
  );

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CAPW'(1);
    end else if (CAPW'(cap_r) > CAPW'(DEPTH)) begin
      eff_cap = CAPW'(DEPTH);
    end else begin
      eff_cap = CAPW'(cap_r);
    end
    full = (CAPW'(cnt_r) >= eff_cap);

    msg_sum = (AW+1)'(rptr_r) + (AW+1)'(cnt_r);
    if (msg_sum >= (AW+1)'(DEPTH)) begin
      msg_sum = msg_sum - (AW+1)'(DEPTH);
    end
    sq_sum = (QAW+1)'(sh_r) + (QAW+1)'(sc_r);
    if (sq_sum >= (QAW+1)'(MAX_TASKS)) begin
      sq_sum = sq_sum - (QAW+1)'(MAX_TASKS);
    end
    rq_sum = (QAW+1)'(rh_r) + (QAW+1)'(rc_r);
    if (rq_sum >= (QAW+1)'(MAX_TASKS)) begin
      rq_sum = rq_sum - (QAW+1)'(MAX_TASKS);
    end
    wait_total = (QCW+1)'(sc_r) + (QCW+1)'(rc_r);
  end

  assign msg_waddr = AW'(msg_sum);
  assign sw_waddr  = QAW'(sq_sum);
  assign rw_waddr  = QAW'(rq_sum);

  always_comb begin
    state_nxt  = state_r;
    rptr_nxt   = rptr_r;
    cnt_nxt    = cnt_r;
    closed_nxt = closed_r;
    sh_nxt     = sh_r;
    sc_nxt     = sc_r;
    rh_nxt     = rh_r;
    rc_nxt     = rc_r;
    req_nxt    = req_r;
    task_nxt   = task_r;
    data_nxt   = data_r;
    msg_we     = 1'b0;
    sw_we      = 1'b0;
    rw_we      = 1'b0;

    out_valid_nxt       = 1'b0;
    out_status_nxt      = ST_OK;
    out_rx_data_nxt     = '0;
    out_woken_valid_nxt = 1'b0;
    out_woken_task_nxt  = '0;
    out_last_nxt        = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_req_type;
          task_nxt  = in_task_id;
          data_nxt  = in_msg_data;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        case (req_r)
          REQ_SEND: begin
            if (closed_r) begin
              out_status_nxt = ST_CLOSED;
            end else if (full) begin
              if (sc_r < QCW'(MAX_TASKS)) begin
                sw_we          = 1'b1;
                sc_nxt         = sc_r + QCW'(1);
                out_status_nxt = ST_BLOCKED;
              end else begin
                out_status_nxt = ST_OVERFLOW;
              end
            end else begin
              msg_we  = 1'b1;
              cnt_nxt = cnt_r + CW'(1);
              if (rc_r != '0) begin
                out_woken_valid_nxt = 1'b1;
                out_woken_task_nxt  = rw_rdata;
                rh_nxt = (rh_r == QAW'(MAX_TASKS - 1)) ? '0 : rh_r + QAW'(1);
                rc_nxt = rc_r - QCW'(1);
              end
            end
          end
          REQ_RECV: begin
            if (closed_r) begin
              out_status_nxt = ST_CLOSED;
            end else if (cnt_r == '0) begin
              if (rc_r < QCW'(MAX_TASKS)) begin
                rw_we          = 1'b1;
                rc_nxt         = rc_r + QCW'(1);
                out_status_nxt = ST_BLOCKED;
              end else begin
                out_status_nxt = ST_OVERFLOW;
              end
            end else begin
              out_rx_data_nxt = msg_rdata;
              rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
              cnt_nxt  = cnt_r - CW'(1);
              if (sc_r != '0) begin
                out_woken_valid_nxt = 1'b1;
                out_woken_task_nxt  = sw_rdata;
                sh_nxt = (sh_r == QAW'(MAX_TASKS - 1)) ? '0 : sh_r + QAW'(1);
                sc_nxt = sc_r - QCW'(1);
              end
            end
          end
          REQ_CLOSE: begin
            closed_nxt = 1'b1;
            cnt_nxt    = '0;
            rptr_nxt   = '0;
            if (wait_total != '0) begin
              out_woken_valid_nxt = 1'b1;
              out_last_nxt        = (wait_total == (QCW+1)'(1));
              state_nxt           = out_last_nxt ? S_IDLE : S_DRAIN;
              if (sc_r != '0) begin
                out_woken_task_nxt = sw_rdata;
                sh_nxt = (sh_r == QAW'(MAX_TASKS - 1)) ? '0 : sh_r + QAW'(1);
                sc_nxt = sc_r - QCW'(1);
              end else begin
                out_woken_task_nxt = rw_rdata;
                rh_nxt = (rh_r == QAW'(MAX_TASKS - 1)) ? '0 : rh_r + QAW'(1);
                rc_nxt = rc_r - QCW'(1);
              end
            end
          end
          REQ_OPEN: begin
            if (closed_r) begin
              closed_nxt = 1'b0;
              cnt_nxt    = '0;
              rptr_nxt   = '0;
              sc_nxt     = '0;
              rc_nxt     = '0;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_DRAIN: begin
        out_valid_nxt       = 1'b1;
        out_woken_valid_nxt = 1'b1;
        out_last_nxt        = (wait_total == (QCW+1)'(1));
        state_nxt           = out_last_nxt ? S_IDLE : S_DRAIN;
        if (sc_r != '0) begin
          out_woken_task_nxt = sw_rdata;
          sh_nxt = (sh_r == QAW'(MAX_TASKS - 1)) ? '0 : sh_r + QAW'(1);
          sc_nxt = sc_r - QCW'(1);
        end else begin
          out_woken_task_nxt = rw_rdata;
          rh_nxt = (rh_r == QAW'(MAX_TASKS - 1)) ? '0 : rh_r + QAW'(1);
          rc_nxt = rc_r - QCW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_msg_count_nxt = CNT_W'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_RESET;
      rptr_r      <= '0;
      cnt_r       <= '0;
      closed_r    <= 1'b0;
      sh_r        <= '0;
      sc_r        <= '0;
      rh_r        <= '0;
      rc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rptr_r      <= rptr_nxt;
      cnt_r       <= cnt_nxt;
      closed_r    <= closed_nxt;
      sh_r        <= sh_nxt;
      sc_r        <= sc_nxt;
      rh_r        <= rh_nxt;
      rc_r        <= rc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r             <= req_nxt;
    task_r            <= task_nxt;
    data_r            <= data_nxt;
    out_status_r      <= out_status_nxt;
    out_rx_data_r     <= out_rx_data_nxt;
    out_woken_valid_r <= out_woken_valid_nxt;
    out_woken_task_r  <= out_woken_task_nxt;
    out_msg_count_r   <= out_msg_count_nxt;
    out_last_r        <= out_last_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_rx_data     = out_rx_data_r;
  assign out_woken_valid = out_woken_valid_r;
  assign out_woken_task  = out_woken_task_r;
  assign out_msg_count   = out_msg_count_r;
  assign out_last        = out_last_r;

endmodule

### sv/bmm_checker.sv
`timescale 1ns / 1ps
`include "blocking_message_mailbox_top_defines.svh"
module bmm_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_valid,
  input logic [1:0]                out_status,
  input logic                      out_woken_valid,
  input logic [bmm_pkg::CNT_W-1:0] out_msg_count,
  input logic                      out_last
);

  import bmm_pkg::*;

  `BMM_ASSERT_NXT(a_accept_goes_busy, start && !busy, busy)
  `BMM_ASSERT_NXT(a_release_beats_back_to_back, out_valid && !out_last, out_valid)
  `BMM_ASSERT_IMP(a_last_beat_frees_block, out_valid && out_last, !busy)
  `BMM_ASSERT_IMP(a_closed_is_empty, out_valid && (out_status == ST_CLOSED), (out_msg_count == '0) && !out_woken_valid)

endmodule

bind blocking_message_mailbox_top bmm_checker u_bmm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_status      (out_status),
  .out_woken_valid (out_woken_valid),
  .out_msg_count   (out_msg_count),
  .out_last        (out_last)
);
